### design/tws_pkg.sv
// Shared constants, types and table-build data for the three-wheel spin mixer.
`default_nettype none

package tws_pkg;

    // Command format: signed fixed point with CMD_FRAC fraction bits.
    localparam int CMD_FRAC = 14;
    localparam int CMD_W    = 16;
    localparam int ANGLE_W  = 24;
    localparam int DELTA_W  = 15;
    localparam int THETA_W  = 15;
    localparam int COS_W    = CMD_FRAC + 1;

    localparam logic signed [CMD_W-1:0] CMD_ONE = CMD_W'(1 << CMD_FRAC);

    localparam int DEF_COS_DEPTH = 1024;

    // Angles in 1/64 degree.
    localparam int TURN_UNITS    = 23040;
    localparam int QUARTER_UNITS = 5760;
    localparam int OFFSET_A      = 0;
    localparam int OFFSET_B      = 7680;
    localparam int OFFSET_C      = 15360;

    // Cosine table build: pi/2 in Q30 and the Taylor term divisors (2k-1)(2k).
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;
    localparam longint unsigned TAYLOR_DIV [1:12] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
    };

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DELTA_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPIN_MAX_DELTA = 1'b0,
        CFG_ALLOW_REVERSE  = 1'b1
    } t_cfg_index;

    // Clamped base, limited delta and wrapped angle handed to each wheel lane.
    typedef struct packed {
        logic                    valid;
        logic signed [CMD_W-1:0] base;
        logic [DELTA_W-1:0]      delta;
        logic [THETA_W-1:0]      theta;
    } t_mix;

endpackage

`default_nettype wire

### design/tws_cos_rom.sv
// Quarter-wave cosine ROM with a registered read port.
`default_nettype none

module tws_cos_rom #(
    parameter int COSINE_TABLE_DEPTH = tws_pkg::DEF_COS_DEPTH
) (
    input  logic                                     i_clk,
    input  logic [$clog2(COSINE_TABLE_DEPTH+1)-1:0]  i_addr,
    output logic [tws_pkg::COS_W-1:0]                o_data
);
    import tws_pkg::*;

    typedef logic [COS_W-1:0] t_cos_arr [0:COSINE_TABLE_DEPTH];

    // Entry i is cos(i * 90deg / depth) from a truncating Q30 Taylor series,
    // rounded half up to command scale and floored at zero.
    function automatic t_cos_arr build_table();
        t_cos_arr        tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          v;
        for (int i = 0; i <= COSINE_TABLE_DEPTH; i++) begin
            x    = (HALF_PI_Q30 * longint'(i)) / COSINE_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = ONE_Q30;
            sum  = longint'(ONE_Q30);
            for (int k = 1; k <= 12; k++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[k];
                if ((k % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v      = ((sum <<< CMD_FRAC) + (64'sd1 <<< 29)) >>> 30;
            tab[i] = COS_W'(v);
        end
        return tab;
    endfunction

    localparam t_cos_arr COS_TABLE = build_table();

    logic [COS_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= COS_TABLE[i_addr];
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

### design/tws_front.sv
// Front pipeline: command clamps, spin scaling, headroom limit and angle wrap.
`default_nettype none

module tws_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_accept,
    input  logic signed [tws_pkg::CMD_W-1:0]      i_base_command,
    input  logic signed [tws_pkg::CMD_W-1:0]      i_spin_command,
    input  logic signed [tws_pkg::ANGLE_W-1:0]    i_spin_angle,
    input  logic [tws_pkg::DELTA_W-1:0]           i_spin_max_delta,
    input  logic                                  i_allow_reverse,
    output tws_pkg::t_mix                         o_mix
);
    import tws_pkg::*;

    // One turn is 512 * 45 units: the low bits pass, the high part is taken mod 45.
    localparam int ANG_LO_W   = 9;
    localparam int ANG_HI_W   = ANGLE_W - ANG_LO_W;
    localparam int WRAP_DIV   = TURN_UNITS >> ANG_LO_W;
    localparam int WRAP_SHIFT = 21;
    localparam int WRAP_RECIP = ((1 << WRAP_SHIFT) + WRAP_DIV - 1) / WRAP_DIV;
    localparam int RECIP_W    = 16;
    localparam int WPROD_W    = ANG_HI_W + RECIP_W;
    localparam int WQ_W       = WPROD_W - WRAP_SHIFT;
    localparam int REM_W      = 6;
    // Flipping the sign bit adds 2^(ANG_HI_W-1); this is its residue mod 45.
    localparam int WRAP_BIAS  = (1 << (ANG_HI_W - 1)) % WRAP_DIV;
    localparam int SPROD_W    = 2 * DELTA_W;
    localparam int ROOM_W     = CMD_W + 2;

    logic signed [CMD_W-1:0] lo_bound;
    assign lo_bound = i_allow_reverse ? -CMD_ONE : '0;

    // Stage 1: clamps and the reciprocal multiply for the angle wrap.
    logic signed [CMD_W-1:0] n_base;
    logic [DELTA_W-1:0]      n_spin;
    logic [ANG_HI_W-1:0]     n_u;
    logic [WPROD_W-1:0]      n_wprod;

    always_comb begin
        if (i_base_command < lo_bound) begin
            n_base = lo_bound;
        end else if (i_base_command > CMD_ONE) begin
            n_base = CMD_ONE;
        end else begin
            n_base = i_base_command;
        end
        if (i_spin_command[CMD_W-1]) begin
            n_spin = '0;
        end else if (i_spin_command > CMD_ONE) begin
            n_spin = DELTA_W'(CMD_ONE);
        end else begin
            n_spin = i_spin_command[DELTA_W-1:0];
        end
        n_u     = {~i_spin_angle[ANGLE_W-1], i_spin_angle[ANGLE_W-2:ANG_LO_W]};
        n_wprod = WPROD_W'(n_u) * WPROD_W'(WRAP_RECIP);
    end

    logic                    r1_valid;
    logic signed [CMD_W-1:0] r1_base;
    logic [DELTA_W-1:0]      r1_spin;
    logic [ANG_HI_W-1:0]     r1_u;
    logic [WPROD_W-1:0]      r1_wprod;
    logic [ANG_LO_W-1:0]     r1_alow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_accept;
        end
        r1_base  <= n_base;
        r1_spin  <= n_spin;
        r1_u     <= n_u;
        r1_wprod <= n_wprod;
        r1_alow  <= i_spin_angle[ANG_LO_W-1:0];
    end

    // Stage 2: requested delta and the wrapped angle.
    logic [WQ_W-1:0]     wq;
    logic [ANG_HI_W-1:0] wrem_full;
    logic [REM_W-1:0]    wrem;
    logic [REM_W-1:0]    wmod;
    logic [SPROD_W-1:0]  sprod;
    logic [DELTA_W-1:0]  n_dreq;
    logic [THETA_W-1:0]  n_theta;

    always_comb begin
        wq        = r1_wprod[WPROD_W-1:WRAP_SHIFT];
        wrem_full = r1_u - ANG_HI_W'(ANG_HI_W'(wq) * ANG_HI_W'(WRAP_DIV));
        wrem      = wrem_full[REM_W-1:0];
        if (wrem >= REM_W'(WRAP_BIAS)) begin
            wmod = wrem - REM_W'(WRAP_BIAS);
        end else begin
            wmod = wrem + REM_W'(WRAP_DIV - WRAP_BIAS);
        end
        n_theta = {wmod, r1_alow};
        sprod   = SPROD_W'(r1_spin) * SPROD_W'(i_spin_max_delta);
        n_dreq  = sprod[CMD_FRAC +: DELTA_W];
    end

    logic                    r2_valid;
    logic signed [CMD_W-1:0] r2_base;
    logic [DELTA_W-1:0]      r2_dreq;
    logic [THETA_W-1:0]      r2_theta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_base  <= r1_base;
        r2_dreq  <= n_dreq;
        r2_theta <= n_theta;
    end

    // Stage 3: shrink delta so that base plus or minus delta stays in range.
    logic signed [ROOM_W-1:0] room_hi;
    logic signed [ROOM_W-1:0] room_lo;
    logic signed [ROOM_W-1:0] dlim;
    logic [DELTA_W-1:0]       n_delta;

    always_comb begin
        room_hi = ROOM_W'(CMD_ONE) - ROOM_W'(r2_base);
        room_lo = ROOM_W'(r2_base) - ROOM_W'(lo_bound);
        dlim    = $signed({{(ROOM_W - DELTA_W){1'b0}}, r2_dreq});
        if (dlim > room_hi) begin
            dlim = room_hi;
        end
        if (dlim > room_lo) begin
            dlim = room_lo;
        end
        n_delta = dlim[DELTA_W-1:0];
    end

    t_mix r3_mix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_mix.valid <= 1'b0;
        end else begin
            r3_mix.valid <= r2_valid;
        end
        r3_mix.base  <= r2_base;
        r3_mix.delta <= n_delta;
        r3_mix.theta <= r2_theta;
    end

    assign o_mix = r3_mix;

endmodule

`default_nettype wire

### design/tws_phase.sv
// One wheel lane: phase offset, quadrant split, table index, cosine term and clamp.
`default_nettype none

module tws_phase #(
    parameter int COSINE_TABLE_DEPTH = tws_pkg::DEF_COS_DEPTH,
    parameter int OFFSET             = tws_pkg::OFFSET_A
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tws_pkg::t_mix                     i_mix,
    input  logic                              i_allow_reverse,
    output logic                              o_valid,
    output logic signed [tws_pkg::CMD_W-1:0]  o_wheel
);
    import tws_pkg::*;

    localparam int KW       = $clog2(COSINE_TABLE_DEPTH + 1);
    localparam int Q_SHIFT  = 7;
    localparam int Q_DIV    = QUARTER_UNITS >> Q_SHIFT;
    localparam int COARSE_W = THETA_W - Q_SHIFT;
    localparam int RR_W     = 6;
    localparam int REST_W   = RR_W + Q_SHIFT;
    localparam int NUM_MAX  = (QUARTER_UNITS - 1) * COSINE_TABLE_DEPTH + QUARTER_UNITS / 2;
    localparam int NW       = $clog2(NUM_MAX + 1);
    localparam int XW       = NW - Q_SHIFT;
    localparam int K_SHIFT  = 24;
    localparam int K_RECIP  = (1 << K_SHIFT) / Q_DIV;
    localparam int RECIP_W  = 19;
    localparam int PW       = XW + RECIP_W;
    localparam int MAG_W    = DELTA_W + COS_W;
    localparam int T_W      = MAG_W - CMD_FRAC;
    localparam int SUM_W    = CMD_W + 2;

    // Stage 1: shift the angle by the wheel offset and split into quadrant and rest.
    logic [THETA_W-1:0]  phase;
    logic [COARSE_W-1:0] coarse;
    logic [1:0]          n_quad;
    logic [COARSE_W-1:0] coarse_rem;
    logic [REST_W-1:0]   n_rest;

    always_comb begin
        if (i_mix.theta >= THETA_W'(OFFSET)) begin
            phase = i_mix.theta - THETA_W'(OFFSET);
        end else begin
            phase = i_mix.theta + THETA_W'(TURN_UNITS - OFFSET);
        end
        coarse = phase[THETA_W-1:Q_SHIFT];
        if (coarse >= COARSE_W'(3 * Q_DIV)) begin
            n_quad     = 2'd3;
            coarse_rem = coarse - COARSE_W'(3 * Q_DIV);
        end else if (coarse >= COARSE_W'(2 * Q_DIV)) begin
            n_quad     = 2'd2;
            coarse_rem = coarse - COARSE_W'(2 * Q_DIV);
        end else if (coarse >= COARSE_W'(Q_DIV)) begin
            n_quad     = 2'd1;
            coarse_rem = coarse - COARSE_W'(Q_DIV);
        end else begin
            n_quad     = 2'd0;
            coarse_rem = coarse;
        end
        n_rest = {coarse_rem[RR_W-1:0], phase[Q_SHIFT-1:0]};
    end

    logic                    r1_valid;
    logic signed [CMD_W-1:0] r1_base;
    logic [DELTA_W-1:0]      r1_delta;
    logic [1:0]              r1_quad;
    logic [REST_W-1:0]       r1_rest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_mix.valid;
        end
        r1_base  <= i_mix.base;
        r1_delta <= i_mix.delta;
        r1_quad  <= n_quad;
        r1_rest  <= n_rest;
    end

    // Stage 2: scale the rest to table steps, with half a step for rounding.
    logic [NW-1:0] num;
    logic [XW-1:0] n_x;

    always_comb begin
        num = NW'(r1_rest) * NW'(COSINE_TABLE_DEPTH) + NW'(QUARTER_UNITS / 2);
        n_x = num[NW-1:Q_SHIFT];
    end

    logic                    r2_valid;
    logic signed [CMD_W-1:0] r2_base;
    logic [DELTA_W-1:0]      r2_delta;
    logic [1:0]              r2_quad;
    logic [XW-1:0]           r2_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_base  <= r1_base;
        r2_delta <= r1_delta;
        r2_quad  <= r1_quad;
        r2_x     <= n_x;
    end

    // Stage 3: quotient estimate by reciprocal; it may fall one short.
    logic [PW-1:0] kprod;
    logic [KW-1:0] n_kest;

    always_comb begin
        kprod  = PW'(r2_x) * PW'(K_RECIP);
        n_kest = KW'(kprod >> K_SHIFT);
    end

    logic                    r3_valid;
    logic signed [CMD_W-1:0] r3_base;
    logic [DELTA_W-1:0]      r3_delta;
    logic [1:0]              r3_quad;
    logic [XW-1:0]           r3_x;
    logic [KW-1:0]           r3_kest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
        r3_base  <= r2_base;
        r3_delta <= r2_delta;
        r3_quad  <= r2_quad;
        r3_x     <= r2_x;
        r3_kest  <= n_kest;
    end

    // Stage 4: correct the index, mirror it in odd quadrants and read the table.
    logic [XW-1:0]    krem;
    logic [KW-1:0]    kidx;
    logic [KW-1:0]    rom_addr;
    logic [COS_W-1:0] rom_data;

    always_comb begin
        krem = r3_x - XW'(XW'(r3_kest) * XW'(Q_DIV));
        kidx = r3_kest + KW'(krem >= XW'(Q_DIV));
        if (r3_quad[0]) begin
            rom_addr = KW'(COSINE_TABLE_DEPTH) - kidx;
        end else begin
            rom_addr = kidx;
        end
    end

    tws_cos_rom #(
        .COSINE_TABLE_DEPTH (COSINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    logic                    r4_valid;
    logic signed [CMD_W-1:0] r4_base;
    logic [DELTA_W-1:0]      r4_delta;
    logic                    r4_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
        r4_base  <= r3_base;
        r4_delta <= r3_delta;
        // The second and third quadrants give a negative cosine.
        r4_neg   <= r3_quad[0] ^ r3_quad[1];
    end

    // Stage 5: magnitude of the spin term.
    logic [MAG_W-1:0] n_mag;
    assign n_mag = MAG_W'(r4_delta) * MAG_W'(rom_data);

    logic                    r5_valid;
    logic signed [CMD_W-1:0] r5_base;
    logic                    r5_neg;
    logic [MAG_W-1:0]        r5_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
        end
        r5_base <= r4_base;
        r5_neg  <= r4_neg;
        r5_mag  <= n_mag;
    end

    // Stage 6: round half away from zero, add to base and clamp.
    logic [MAG_W-1:0]        mag_rnd;
    logic [T_W-1:0]          term;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] hi_b;
    logic signed [SUM_W-1:0] lo_b;
    logic signed [CMD_W-1:0] n_wheel;

    always_comb begin
        mag_rnd = r5_mag + MAG_W'(1 << (CMD_FRAC - 1));
        term    = mag_rnd[CMD_FRAC +: T_W];
        if (r5_neg) begin
            sum = SUM_W'(r5_base) - $signed({{(SUM_W - T_W){1'b0}}, term});
        end else begin
            sum = SUM_W'(r5_base) + $signed({{(SUM_W - T_W){1'b0}}, term});
        end
        hi_b = SUM_W'(CMD_ONE);
        lo_b = i_allow_reverse ? -hi_b : '0;
        if (sum < lo_b) begin
            sum = lo_b;
        end
        if (sum > hi_b) begin
            sum = hi_b;
        end
        n_wheel = sum[CMD_W-1:0];
    end

    logic                    r_valid;
    logic signed [CMD_W-1:0] r_wheel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r5_valid;
        end
        r_wheel <= n_wheel;
    end

    assign o_valid = r_valid;
    assign o_wheel = r_wheel;

endmodule

`default_nettype wire

### design/three_wheel_spin_mixer.sv
// Top level of the three-wheel spin mixer: configuration registers and the wheel lanes.
//
//  Channel   Signals                                         Direction  Handshake
//  request   start, busy, i_base_command, i_spin_command,    in         start && !busy
//            i_spin_angle
//  result    o_valid, o_wheel_a, o_wheel_b, o_wheel_c        out        o_valid strobe
//  config    i_cfg_we, i_cfg_index, i_cfg_data               in         i_cfg_we
//
// A request can be taken in every cycle; its result appears on o_valid for one
// cycle. The pipeline depth comes from the angle wrap and the table index, each
// a reciprocal multiply, plus the registered cosine ROM and the spin product.
// busy is high only while reset is held. Reset is synchronous and clears the
// pipeline valid bits and both configuration registers. Nothing ever stalls.
`default_nettype none

module three_wheel_spin_mixer #(
    parameter int COSINE_TABLE_DEPTH = tws_pkg::DEF_COS_DEPTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [tws_pkg::CMD_W-1:0]      i_base_command,
    input  logic signed [tws_pkg::CMD_W-1:0]      i_spin_command,
    input  logic signed [tws_pkg::ANGLE_W-1:0]    i_spin_angle,
    input  logic                                  i_cfg_we,
    input  logic [tws_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [tws_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output logic                                  o_valid,
    output logic signed [tws_pkg::CMD_W-1:0]      o_wheel_a,
    output logic signed [tws_pkg::CMD_W-1:0]      o_wheel_b,
    output logic signed [tws_pkg::CMD_W-1:0]      o_wheel_c
);
    import tws_pkg::*;

    logic [DELTA_W-1:0] r_spin_max_delta;
    logic               r_allow_reverse;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spin_max_delta <= '0;
            r_allow_reverse  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SPIN_MAX_DELTA: begin
                    r_spin_max_delta <= i_cfg_data[DELTA_W-1:0];
                end
                CFG_ALLOW_REVERSE: begin
                    r_allow_reverse <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    logic accept;
    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    t_mix mix;

    tws_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_base_command   (i_base_command),
        .i_spin_command   (i_spin_command),
        .i_spin_angle     (i_spin_angle),
        .i_spin_max_delta (r_spin_max_delta),
        .i_allow_reverse  (r_allow_reverse),
        .o_mix            (mix)
    );

    tws_phase #(
        .COSINE_TABLE_DEPTH (COSINE_TABLE_DEPTH),
        .OFFSET             (OFFSET_A)
    ) u_phase_a (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mix           (mix),
        .i_allow_reverse (r_allow_reverse),
        .o_valid         (o_valid),
        .o_wheel         (o_wheel_a)
    );

    // The other two lanes run in lockstep, so their valid outputs are not needed.
    tws_phase #(
        .COSINE_TABLE_DEPTH (COSINE_TABLE_DEPTH),
        .OFFSET             (OFFSET_B)
    ) u_phase_b (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mix           (mix),
        .i_allow_reverse (r_allow_reverse),
        .o_valid         (),
        .o_wheel         (o_wheel_b)
    );

    tws_phase #(
        .COSINE_TABLE_DEPTH (COSINE_TABLE_DEPTH),
        .OFFSET             (OFFSET_C)
    ) u_phase_c (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mix           (mix),
        .i_allow_reverse (r_allow_reverse),
        .o_valid         (),
        .o_wheel         (o_wheel_c)
    );

endmodule

`default_nettype wire

### tb/tb_three_wheel_spin_mixer.sv
// Self-checking testbench for the three-wheel spin mixer with its own wheel command predictor.
`default_nettype none

module tb_three_wheel_spin_mixer;
    timeunit 1ns;
    timeprecision 1ps;

    import tws_pkg::*;

    localparam int     COS_DEPTH   = DEF_COS_DEPTH;
    localparam longint ONE         = 64'sd1 <<< CMD_FRAC;
    localparam longint HALF_LSB    = 64'sd1 <<< (CMD_FRAC - 1);
    localparam longint TURN        = 23040;
    localparam longint QUARTER     = 5760;
    localparam longint PHASE_B     = 7680;
    localparam longint PHASE_C     = 15360;
    localparam longint unsigned HALF_PI_FIX = 64'd1686629713;
    localparam longint unsigned UNIT_FIX    = 64'd1 << 30;
    localparam int     STALL_LIMIT = 2000;
    localparam int     SETTLE_CYCLES = 16;

    typedef struct {
        logic signed [CMD_W-1:0] a;
        logic signed [CMD_W-1:0] b;
        logic signed [CMD_W-1:0] c;
    } t_wheel_set;

    // Works out the three wheel commands of each accepted request and checks them in order.
    class wheel_drive_checker;
        longint     cos_quarter[COS_DEPTH+1];
        longint     max_delta;
        bit         reverse_ok;
        t_wheel_set wheel_sets_due[$];
        int         mismatches;
        int         requests_seen;
        int         results_seen;

        function new();
            longint unsigned x, x2, term;
            longint sum;
            for (int i = 0; i <= COS_DEPTH; i++) begin
                x    = (HALF_PI_FIX * 64'(i)) / 64'(COS_DEPTH);
                x2   = (x * x) >> 30;
                term = UNIT_FIX;
                sum  = longint'(UNIT_FIX);
                // Taylor series of the cosine, each term truncated after its divide.
                for (int k = 1; k <= 12; k++) begin
                    term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
                    if (k % 2 == 1) begin
                        sum -= longint'(term);
                    end else begin
                        sum += longint'(term);
                    end
                end
                if (sum < 0) begin
                    sum = 0;
                end
                cos_quarter[i] = (sum * ONE + (64'sd1 <<< 29)) >>> 30;
            end
            max_delta  = 0;
            reverse_ok = 1'b0;
        endfunction

        function void set_config(longint spin_max, bit rev);
            max_delta  = spin_max;
            reverse_ok = rev;
        endfunction

        function longint wrap_turn(longint a);
            longint w;
            w = a % TURN;
            if (w < 0) begin
                w += TURN;
            end
            return w;
        endfunction

        function longint cosine_at(longint p);
            longint q, r, k;
            q = p / QUARTER;
            r = p % QUARTER;
            k = (r * COS_DEPTH + QUARTER / 2) / QUARTER;
            if (k > COS_DEPTH) begin
                k = COS_DEPTH;
            end
            if (k < 0) begin
                k = 0;
            end
            case (q % 4)
                0: return cos_quarter[k];
                1: return -cos_quarter[COS_DEPTH - k];
                2: return -cos_quarter[k];
                default: return cos_quarter[COS_DEPTH - k];
            endcase
        endfunction

        function logic signed [CMD_W-1:0] wheel_drive(longint base, longint delta,
                                                      longint phase, longint lo, longint hi);
            longint prod, mag, t, v;
            prod = delta * cosine_at(wrap_turn(phase));
            mag  = (prod < 0) ? -prod : prod;
            t    = (mag + HALF_LSB) >>> CMD_FRAC;
            v    = base + ((prod < 0) ? -t : t);
            if (v < lo) begin
                v = lo;
            end
            if (v > hi) begin
                v = hi;
            end
            return CMD_W'(v);
        endfunction

        function void note_request(logic signed [CMD_W-1:0] base_cmd,
                                   logic signed [CMD_W-1:0] spin_cmd,
                                   logic signed [ANGLE_W-1:0] angle);
            longint lo, hi, base, spin, theta, delta;
            t_wheel_set w;
            lo    = reverse_ok ? -ONE : 0;
            hi    = ONE;
            base  = base_cmd;
            spin  = spin_cmd;
            theta = wrap_turn(angle);
            if (base < lo) begin
                base = lo;
            end
            if (base > hi) begin
                base = hi;
            end
            if (spin < 0) begin
                spin = 0;
            end
            if (spin > ONE) begin
                spin = ONE;
            end
            // The requested delta is cut back so that both base+delta and base-delta stay in range.
            delta = (spin * max_delta) >>> CMD_FRAC;
            if (delta > hi - base) begin
                delta = hi - base;
            end
            if (delta > base - lo) begin
                delta = base - lo;
            end
            if (delta < 0) begin
                delta = 0;
            end
            w.a = wheel_drive(base, delta, theta, lo, hi);
            w.b = wheel_drive(base, delta, theta - PHASE_B, lo, hi);
            w.c = wheel_drive(base, delta, theta - PHASE_C, lo, hi);
            wheel_sets_due.push_back(w);
            requests_seen++;
        endfunction

        function void check_wheels(logic signed [CMD_W-1:0] a, logic signed [CMD_W-1:0] b,
                                   logic signed [CMD_W-1:0] c);
            t_wheel_set w;
            results_seen++;
            if (wheel_sets_due.size() == 0) begin
                $error("result with no request outstanding: a=%0d b=%0d c=%0d", a, b, c);
                mismatches++;
                return;
            end
            w = wheel_sets_due.pop_front();
            if (a !== w.a) begin
                $error("wheel_a: expected %0d, got %0d", w.a, a);
                mismatches++;
            end
            if (b !== w.b) begin
                $error("wheel_b: expected %0d, got %0d", w.b, b);
                mismatches++;
            end
            if (c !== w.c) begin
                $error("wheel_c: expected %0d, got %0d", w.c, c);
                mismatches++;
            end
        endfunction

        function int pending();
            return wheel_sets_due.size();
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic signed [CMD_W-1:0]   i_base_command = '0;
    logic signed [CMD_W-1:0]   i_spin_command = '0;
    logic signed [ANGLE_W-1:0] i_spin_angle = '0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = CFG_SPIN_MAX_DELTA;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;
    logic                      o_valid;
    logic signed [CMD_W-1:0]   o_wheel_a;
    logic signed [CMD_W-1:0]   o_wheel_b;
    logic signed [CMD_W-1:0]   o_wheel_c;

    wheel_drive_checker wheels = new();
    int quiet_cycles = 0;
    int settings_used = 0;

    three_wheel_spin_mixer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_base_command (i_base_command),
        .i_spin_command (i_spin_command),
        .i_spin_angle   (i_spin_angle),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_wheel_a      (o_wheel_a),
        .o_wheel_b      (o_wheel_b),
        .o_wheel_c      (o_wheel_c)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Requests and results are both taken at the rising edge, from the values before it.
    always @(posedge i_clk) begin
        if (start && !busy) begin
            wheels.note_request(i_base_command, i_spin_command, i_spin_angle);
        end
        if (o_valid === 1'b1) begin
            wheels.check_wheels(o_wheel_a, o_wheel_b, o_wheel_c);
        end
        if ((start && !busy) || o_valid === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input logic signed [CMD_W-1:0] base_cmd,
                                input logic signed [CMD_W-1:0] spin_cmd,
                                input logic signed [ANGLE_W-1:0] angle);
        start          <= 1'b1;
        i_base_command <= base_cmd;
        i_spin_command <= spin_cmd;
        i_spin_angle   <= angle;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    // Fields carry junk while start is low; the block must ignore it.
    task automatic idle_cycles(input int n);
        start          <= 1'b0;
        i_base_command <= CMD_W'($urandom);
        i_spin_command <= CMD_W'($urandom);
        i_spin_angle   <= ANGLE_W'($urandom);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (wheels.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Only called with the block idle; writes both registers on consecutive edges.
    task automatic write_config(input logic [CFG_DATA_W-1:0] spin_max, input logic rev);
        logic [CFG_DATA_W-1:0] rev_word;
        rev_word    = (CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1)) | CFG_DATA_W'(rev);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SPIN_MAX_DELTA;
        i_cfg_data  <= spin_max;
        @(posedge i_clk);
        i_cfg_index <= CFG_ALLOW_REVERSE;
        i_cfg_data  <= rev_word;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        wheels.set_config(spin_max, rev);
        settings_used++;
    endtask

    task automatic random_request();
        logic signed [CMD_W-1:0]   base_cmd;
        logic signed [CMD_W-1:0]   spin_cmd;
        logic signed [ANGLE_W-1:0] angle;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            base_cmd = CMD_W'($urandom);
        end else if (pick == 1) begin
            case ($urandom_range(0, 4))
                0: base_cmd = -16384;
                1: base_cmd = 0;
                2: base_cmd = 16384;
                3: base_cmd = -16385;
                default: base_cmd = 16385;
            endcase
        end else begin
            base_cmd = CMD_W'(int'($urandom_range(0, 32768)) - 16384);
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            spin_cmd = CMD_W'($urandom);
        end else if (pick == 1) begin
            case ($urandom_range(0, 3))
                0: spin_cmd = 0;
                1: spin_cmd = 16384;
                2: spin_cmd = -1;
                default: spin_cmd = 16385;
            endcase
        end else begin
            spin_cmd = CMD_W'($urandom_range(0, 16384));
        end
        pick = $urandom_range(0, 9);
        if (pick <= 2) begin
            angle = ANGLE_W'($urandom);
        end else if (pick == 3) begin
            // Near a quadrant boundary, possibly several turns away, to hit the table ends.
            angle = ANGLE_W'(int'($urandom_range(0, 3)) * 5760 + int'($urandom_range(0, 8)) - 4
                    + (int'($urandom_range(0, 8)) - 4) * 23040);
        end else begin
            angle = ANGLE_W'($urandom_range(0, 23039));
        end
        send_request(base_cmd, spin_cmd, angle);
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] spin_max;
        logic rev;
        bit idling;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers at their reset values: no spin and no reverse, so only the clamped base shows.
        send_request(-32768, 16384, 0);
        send_request(32767, 16384, 5760);
        send_request(16384, 0, 0);
        send_request(-16384, 32767, 11520);
        drain_results();

        write_config(16384, 1'b1);
        send_request(0, 16384, 0);
        send_request(0, 16384, -1);
        send_request(0, 16384, 23040);
        send_request(0, 16384, 5760);
        send_request(0, 16384, 11520);
        send_request(0, 16384, 17280);
        send_request(0, 16384, 8388607);
        send_request(0, 16384, -8388608);
        send_request(0, -32768, 2880);
        send_request(0, -1, 100);
        send_request(16384, 16384, 0);
        send_request(-16384, 16384, 0);
        send_request(8192, 16384, 2880);
        send_request(-8192, 8192, 20000);
        drain_results();

        // Oversized maximum delta, forward only: the headroom limit has to do the work.
        write_config(32767, 1'b0);
        send_request(8192, 16384, 0);
        send_request(8192, 32767, 12000);
        send_request(32767, 16384, 3000);
        send_request(-1, 16384, 0);
        send_request(4000, 16384, 5759);
        send_request(12000, 16384, 17279);

        for (int ph = 0; ph < 8; ph++) begin
            drain_results();
            case (ph)
                0: begin spin_max = 16384; rev = 1'b1; end
                1: begin spin_max = 16384; rev = 1'b0; end
                2: begin spin_max = 32767; rev = 1'b1; end
                3: begin spin_max = 8192;  rev = 1'b0; end
                4: begin spin_max = 1;     rev = 1'b1; end
                5: begin spin_max = CFG_DATA_W'($urandom); rev = 1'($urandom); end
                6: begin spin_max = CFG_DATA_W'($urandom_range(0, 16384)); rev = 1'b1; end
                default: begin spin_max = 16384; rev = 1'b1; end
            endcase
            write_config(spin_max, rev);
            idling = (ph != 7) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 68; n++) begin
                random_request();
                if (idling && $urandom_range(0, 5) == 0) begin
                    idle_cycles($urandom_range(1, 16));
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (wheels.pending() != 0) begin
            $error("%0d wheel sets never came out", wheels.pending());
            wheels.mismatches++;
        end
        $display("Ran %0d requests under %0d register settings; %0d wheel sets compared.",
                 wheels.requests_seen, settings_used + 1, wheels.results_seen);
        if (wheels.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
